### hdl/psd_pkg.sv
package psd_pkg;

    localparam int PIX_W     = 12;
    localparam int STR_W     = 8;
    localparam int DEPTH_W   = 2;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_SPATIAL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_SPATIAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_TEMPORAL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_TEMPORAL = 3'd4;

    localparam logic [DEPTH_W-1:0] DEPTH_8  = 2'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_10 = 2'd1;

    localparam logic [STR_W-1:0] STR_FLOOR = 8'd4;

    // ln2 in Q.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [33:0] ONE_Q32 = 34'h1_0000_0000;
    // floor(2^63 / LN2_Q32), reciprocal for the range reduction
    localparam logic [31:0] LN2_RCP = 32'((64'd1 << 63) / 64'(LN2_Q32));

    // exponent scaling divider: (d^2 << 32 + den/2) / den
    localparam int X_NUM_W = 57;
    localparam int X_DEN_W = 32;
    localparam int X_Q_W   = 31;
    localparam int K_W     = 8;
    localparam int EXP_TERMS = 13;

    // input register to weight output register
    localparam int WGT_LAT = 3 + X_Q_W + 3 + 3 * (EXP_TERMS - 1) + 1;

    function automatic logic [PIX_W-1:0] peak_of(input logic [DEPTH_W-1:0] mode);
        logic [PIX_W-1:0] pk;
        case (mode)
            DEPTH_8:  pk = 12'h0FF;
            DEPTH_10: pk = 12'h3FF;
            default:  pk = 12'hFFF;
        endcase
        return pk;
    endfunction

    function automatic logic [2*PIX_W-1:0] peak_sq(input logic [DEPTH_W-1:0] mode);
        logic [2*PIX_W-1:0] pq;
        case (mode)
            DEPTH_8:  pq = 24'd65025;
            DEPTH_10: pq = 24'd1046529;
            default:  pq = 24'd16769025;
        endcase
        return pq;
    endfunction

endpackage

### hdl/psd_delay.sv
module psd_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] pipe_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= din;
            for (int i = 1; i < N; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign dout = pipe_reg[N-1];

endmodule

### hdl/psd_div.sv
// Restoring divider, one quotient bit per stage. Needs num < den * 2^Q_W.
module psd_div #(
    parameter int NUM_W = 57,
    parameter int DEN_W = 32,
    parameter int Q_W   = 31
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   low_reg [Q_W];
    logic [Q_W-1:0]   q_reg   [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];

    for (genvar i = 0; i < Q_W; i++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [Q_W-1:0]   low_in;
        logic [Q_W-1:0]   q_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        if (i == 0)
        begin : g_first
            assign rem_in = DEN_W'(num[NUM_W-1:Q_W]);
            assign low_in = num[Q_W-1:0];
            assign q_in   = '0;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign low_in = low_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        assign trial    = {rem_in, low_in[Q_W-1]};
        assign diff     = trial - {1'b0, den_in};
        assign ge       = trial >= {1'b0, den_in};
        assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                low_reg[i] <= {low_in[Q_W-2:0], 1'b0};
                q_reg[i]   <= {q_in[Q_W-2:0], ge};
                den_reg[i] <= den_in;
            end
        end
    end

    assign quo = q_reg[Q_W-1];

endmodule

### hdl/psd_weight.sv
// w = exp(-(d/peak)^2 * 16 / max(0.25, s)) in Q1.F, WGT_LAT stages; w = 0 when strength is 0.
module psd_weight
    import psd_pkg::*;
#(
    parameter int FRAC_W = 16
) (
    input  logic               clk,
    input  logic               en,
    input  logic [DEPTH_W-1:0] depth_mode,
    input  logic [STR_W-1:0]   strength,
    input  logic [PIX_W-1:0]   pel_a,
    input  logic [PIX_W-1:0]   pel_b,
    output logic [FRAC_W:0]    weight
);

    localparam logic [FRAC_W:0] ONE = {1'b1, {FRAC_W{1'b0}}};
    localparam int NT = EXP_TERMS - 1;

    typedef struct packed {
        logic [31:0]    rem;
        logic [K_W-1:0] k;
        logic           zero;
    } kbus_t;

    typedef struct packed {
        logic [31:0]    r;
        logic [K_W-1:0] k;
        logic           zero;
        logic [33:0]    sum;
        logic [31:0]    t;
        logic [31:0]    q;
    } ebus_t;

    // front: difference, square, scale
    logic [PIX_W-1:0]   d1_reg;
    logic [STR_W-1:0]   s1_reg;
    logic               zero1_reg;
    logic [2*PIX_W-1:0] d2_reg;
    logic [X_DEN_W-1:0] den2_reg;
    logic               zero2_reg;
    logic [X_NUM_W-1:0] num3_reg;
    logic [X_DEN_W-1:0] den3_reg;
    logic               zero3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg    <= (pel_a > pel_b) ? pel_a - pel_b : pel_b - pel_a;
            s1_reg    <= (strength < STR_FLOOR) ? STR_FLOOR : strength;
            zero1_reg <= strength == '0;
            d2_reg    <= d1_reg * d1_reg;
            den2_reg  <= X_DEN_W'(peak_sq(depth_mode)) * X_DEN_W'(s1_reg);
            zero2_reg <= zero1_reg;
            num3_reg  <= {1'b0, d2_reg, 32'd0} + X_NUM_W'(den2_reg[X_DEN_W-1:1]);
            den3_reg  <= den2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    logic [X_Q_W-1:0] x24;
    logic             zero_x;

    psd_div #(.NUM_W(X_NUM_W), .DEN_W(X_DEN_W), .Q_W(X_Q_W)) u_xdiv (
        .clk (clk),
        .en  (en),
        .num (num3_reg),
        .den (den3_reg),
        .quo (x24)
    );

    psd_delay #(.W(1), .N(X_Q_W)) u_zdly (
        .clk  (clk),
        .en   (en),
        .din  (zero3_reg),
        .dout (zero_x)
    );

    // range reduction: k = floor((x24 << 8) / ln2), r = remainder.
    // Reciprocal estimate is at most one low, fixed by one compare and subtract.
    logic [62:0]      kp1_reg;
    logic [X_Q_W-1:0] x1_reg;
    logic             zero_k1_reg;
    logic [32:0]      re2_reg;
    logic [K_W-1:0]   ke2_reg;
    logic             zero_k2_reg;
    logic [39:0]      kl;
    logic [32:0]      re_next;
    logic             re_ge;
    kbus_t            kr_reg;

    assign kl      = 40'(kp1_reg[62 -: K_W]) * 40'(LN2_Q32);
    assign re_next = 33'({1'b0, x1_reg, 8'd0} - kl);
    assign re_ge   = re2_reg >= {1'b0, LN2_Q32};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kp1_reg     <= 63'(x24) * 63'(LN2_RCP);
            x1_reg      <= x24;
            zero_k1_reg <= zero_x;
            re2_reg     <= re_next;
            ke2_reg     <= kp1_reg[62 -: K_W];
            zero_k2_reg <= zero_k1_reg;
            kr_reg.rem  <= re_ge ? 32'(re2_reg - {1'b0, LN2_Q32}) : re2_reg[31:0];
            kr_reg.k    <= ke2_reg + K_W'(re_ge);
            kr_reg.zero <= zero_k2_reg;
        end
    end

    // exp(-r) Taylor series; term n in three stages: t*r, /n estimate, correct and sum
    ebus_t pa_reg [NT];
    ebus_t pb_reg [NT];
    ebus_t pc_reg [NT];

    for (genvar j = 0; j < NT; j++)
    begin : g_term
        localparam int          N   = j + 2;
        localparam logic [31:0] RCP = 32'((64'd1 << 32) / N);

        ebus_t       ein;
        ebus_t       a_next;
        ebus_t       b_next;
        ebus_t       c_next;
        logic [63:0] prod_a;
        logic [63:0] prod_b;
        logic [35:0] qn;
        logic [35:0] rem;
        logic [31:0] q;

        if (j == 0)
        begin : g_first
            assign ein.r    = kr_reg.rem;
            assign ein.k    = kr_reg.k;
            assign ein.zero = kr_reg.zero;
            assign ein.sum  = ONE_Q32 - 34'(kr_reg.rem);
            assign ein.t    = kr_reg.rem;
            assign ein.q    = '0;
        end
        else
        begin : g_rest
            assign ein = pc_reg[j-1];
        end

        assign prod_a = 64'(ein.t) * 64'(ein.r);
        assign prod_b = 64'(pa_reg[j].t) * 64'(RCP);
        assign qn     = 36'(pb_reg[j].q) * 36'(N);
        assign rem    = 36'(pb_reg[j].t) - qn;
        assign q      = pb_reg[j].q + 32'(rem >= 36'(N));

        always_comb
        begin
            a_next   = ein;
            a_next.t = prod_a[63:32];
            b_next   = pa_reg[j];
            b_next.q = prod_b[63:32];
            c_next   = pb_reg[j];
            c_next.t = q;
            if (N % 2 == 1)
            begin
                c_next.sum = pb_reg[j].sum - 34'(q);
            end
            else
            begin
                c_next.sum = pb_reg[j].sum + 34'(q);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pa_reg[j] <= a_next;
                pb_reg[j] <= b_next;
                pc_reg[j] <= c_next;
            end
        end
    end

    // w = (E + 2^(sh-1)) >> sh, sh = 32 - F + k; nothing left past sh = 40
    ebus_t       efin;
    logic [8:0]  sh;
    logic        kill;
    logic [40:0] rnd;
    logic [40:0] wsh;
    logic [FRAC_W:0] weight_reg;

    assign efin = pc_reg[NT-1];
    assign sh   = 9'(32 - FRAC_W) + {1'b0, efin.k};
    assign kill = efin.zero || (efin.k > K_W'(FRAC_W + 8));
    assign rnd  = 41'(efin.sum[32:0]) + (41'd1 << (sh - 9'd1));
    assign wsh  = rnd >> sh;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (kill)
            begin
                weight_reg <= '0;
            end
            else if (wsh > 41'(ONE))
            begin
                weight_reg <= ONE;
            end
            else
            begin
                weight_reg <= wsh[FRAC_W:0];
            end
        end
    end

    assign weight = weight_reg;

endmodule

### hdl/pixel_spatiotemporal_denoiser.sv
// channel | dir | contents (lowest bits first)
// s_*     | in  | tdata: centre, left_pel, right_pel, above_pel, below_pel, previous_pel
//         |     | tuser: has_previous, is_luma
// m_*     | out | tdata: filtered_pel, zero fill to 16 bits
// cfg_*   | in  | write of depth_mode, luma/chroma spatial, luma/chroma temporal
// One pixel per clock sustained while the output is not stalled. Most of the pipeline
// depth comes from the weight divider and the mean divider, one quotient bit per stage,
// and the 13-term exp series, three stages per term.
// Reset clears the valid line and loads the register defaults.
// A stalled result freezes the whole pipeline; s_tready follows it.
module pixel_spatiotemporal_denoiser
    import psd_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [71:0]          s_tdata,   // centre, left, right, above, below, previous
    input  logic [1:0]           s_tuser,   // has_previous, is_luma
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // filtered_pel, zero fill
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [STR_W-1:0]     cfg_wdata
);

    localparam int F      = WEIGHT_FRAC_BITS;
    localparam int W_W    = F + 1;
    localparam int PROD_W = F + 13;
    localparam int ACC_W  = F + 15;
    localparam int WS_W   = F + 3;
    localparam int NUM_W  = 2 * F + 15;
    localparam int Q_W    = F + 12;
    localparam int B_W    = 2 * F + 14;
    localparam int VLD_N  = WGT_LAT + Q_W + 5;
    localparam int D0_W   = 6 * PIX_W + 1;
    localparam int SD_W   = PIX_W + 1 + W_W;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    // configuration
    logic [DEPTH_W-1:0] depth_mode_reg;
    logic [STR_W-1:0]   luma_spatial_reg;
    logic [STR_W-1:0]   chroma_spatial_reg;
    logic [STR_W-1:0]   luma_temporal_reg;
    logic [STR_W-1:0]   chroma_temporal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg      <= DEPTH_8;
            luma_spatial_reg    <= 8'd64;
            chroma_spatial_reg  <= 8'd48;
            luma_temporal_reg   <= 8'd96;
            chroma_temporal_reg <= 8'd72;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEPTH_MODE:      depth_mode_reg      <= cfg_wdata[DEPTH_W-1:0];
                REG_LUMA_SPATIAL:    luma_spatial_reg    <= cfg_wdata;
                REG_CHROMA_SPATIAL:  chroma_spatial_reg  <= cfg_wdata;
                REG_LUMA_TEMPORAL:   luma_temporal_reg   <= cfg_wdata;
                REG_CHROMA_TEMPORAL: chroma_temporal_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic             en;
    logic [VLD_N-1:0] vld_reg;

    assign m_tvalid = vld_reg[VLD_N-1];
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[VLD_N-2:0], s_tvalid};
        end
    end

    // input register, pixels reduced to the bit depth
    logic [PIX_W-1:0] peak;
    logic [PIX_W-1:0] pel_reg [5];
    logic [PIX_W-1:0] prev_reg;
    logic             has_prev_reg;
    logic             luma_reg;

    assign peak = peak_of(depth_mode_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 5; i++)
            begin
                pel_reg[i] <= s_tdata[i*PIX_W +: PIX_W] & peak;
            end
            prev_reg     <= s_tdata[5*PIX_W +: PIX_W] & peak;
            has_prev_reg <= s_tuser[0];
            luma_reg     <= s_tuser[1];
        end
    end

    logic [STR_W-1:0] sp;
    logic [STR_W-1:0] tp;

    assign sp = luma_reg ? luma_spatial_reg  : chroma_spatial_reg;
    assign tp = luma_reg ? luma_temporal_reg : chroma_temporal_reg;

    // weights
    logic [W_W-1:0] nb_w [4];
    logic [W_W-1:0] tw;

    for (genvar i = 0; i < 4; i++)
    begin : g_nb
        psd_weight #(.FRAC_W(F)) u_wgt (
            .clk        (clk),
            .en         (en),
            .depth_mode (depth_mode_reg),
            .strength   (sp),
            .pel_a      (pel_reg[i+1]),
            .pel_b      (pel_reg[0]),
            .weight     (nb_w[i])
        );
    end

    psd_weight #(.FRAC_W(F)) u_twgt (
        .clk        (clk),
        .en         (en),
        .depth_mode (depth_mode_reg),
        .strength   (tp),
        .pel_a      (prev_reg),
        .pel_b      (pel_reg[0]),
        .weight     (tw)
    );

    logic [D0_W-1:0] d0_in;
    logic [D0_W-1:0] d0_out;

    assign d0_in = {has_prev_reg, prev_reg, pel_reg[4], pel_reg[3], pel_reg[2],
                    pel_reg[1], pel_reg[0]};

    psd_delay #(.W(D0_W), .N(WGT_LAT)) u_d0 (
        .clk  (clk),
        .en   (en),
        .din  (d0_in),
        .dout (d0_out)
    );

    // weighted products
    logic [PROD_W-1:0] prod_reg [4];
    logic [WS_W-1:0]   ws_reg;
    logic [PIX_W-1:0]  c_p_reg;
    logic [PIX_W-1:0]  prev_p_reg;
    logic              hp_p_reg;
    logic [W_W-1:0]    tw_p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_reg[i] <= PROD_W'(d0_out[(i+1)*PIX_W +: PIX_W]) * PROD_W'(nb_w[i]);
            end
            ws_reg     <= WS_W'(ONE) + WS_W'(nb_w[0]) + WS_W'(nb_w[1])
                        + WS_W'(nb_w[2]) + WS_W'(nb_w[3]);
            c_p_reg    <= d0_out[PIX_W-1:0];
            prev_p_reg <= d0_out[5*PIX_W +: PIX_W];
            hp_p_reg   <= d0_out[D0_W-1];
            tw_p_reg   <= tw;
        end
    end

    // mean numerator, rounded to nearest by ws/2
    logic [ACC_W-1:0] acc;
    logic [NUM_W-1:0] numer_reg;
    logic [WS_W-1:0]  den_reg;
    logic [SD_W-1:0]  sd_reg;

    assign acc = (ACC_W'(c_p_reg) << F) + ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1])
               + ACC_W'(prod_reg[2]) + ACC_W'(prod_reg[3]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numer_reg <= (NUM_W'(acc) << F) + NUM_W'(ws_reg[WS_W-1:1]);
            den_reg   <= ws_reg;
            sd_reg    <= {tw_p_reg, hp_p_reg, prev_p_reg};
        end
    end

    logic [Q_W-1:0]  mean;
    logic [SD_W-1:0] sd_out;

    psd_div #(.NUM_W(NUM_W), .DEN_W(WS_W), .Q_W(Q_W)) u_mdiv (
        .clk (clk),
        .en  (en),
        .num (numer_reg),
        .den (den_reg),
        .quo (mean)
    );

    psd_delay #(.W(SD_W), .N(Q_W)) u_sd (
        .clk  (clk),
        .en   (en),
        .din  (sd_reg),
        .dout (sd_out)
    );

    // temporal blend products
    logic [PIX_W-1:0] prev_m;
    logic             hp_m;
    logic [W_W-1:0]   tw_m;
    logic [B_W-1:0]   pm_reg;
    logic [B_W-1:0]   pt_reg;
    logic [Q_W-1:0]   mean_reg;
    logic             hp_b_reg;

    assign prev_m = sd_out[PIX_W-1:0];
    assign hp_m   = sd_out[PIX_W];
    assign tw_m   = sd_out[SD_W-1:PIX_W+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pm_reg   <= B_W'(mean) * B_W'(ONE - tw_m);
            pt_reg   <= B_W'(prev_m) * B_W'(tw_m);
            mean_reg <= mean;
            hp_b_reg <= hp_m;
        end
    end

    // rounding and clamp
    logic [B_W-1:0]   blend;
    logic [Q_W:0]     mrnd;
    logic [13:0]      res;
    logic [PIX_W-1:0] out_reg;

    assign blend = pm_reg + (pt_reg << F) + (B_W'(1) << (2 * F - 1));
    assign mrnd  = (Q_W + 1)'(mean_reg) + ((Q_W + 1)'(1) << (F - 1));
    assign res   = hp_b_reg ? blend[B_W-1:2*F] : 14'(mrnd[Q_W:F]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= (res > 14'(peak)) ? peak : res[PIX_W-1:0];
        end
    end

    assign m_tdata = {4'd0, out_reg};

endmodule

### hdl/psd_checker.sv
module psd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // requests are taken exactly when the pipeline can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready out of step with output stall");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:12] == 4'd0)
        else $error("pad bits of m_tdata set");

    a_rst: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid straight out of reset");

endmodule

bind pixel_spatiotemporal_denoiser psd_checker u_psd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
